### rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int IDX_W       = 13;
	localparam int CNT_W       = 13;
	localparam int FIELD_W     = 48;
	localparam int CFG_INDEX_W = 8;
	localparam int WORD_W      = 64;
	localparam int WORD_SH     = 6;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 8'd1;

	typedef enum logic [1:0] {
		K_NONE,
		K_ALLOC,
		K_FREE,
		K_QUERY
	} bfa_kind_t;

	typedef struct packed {
		bfa_kind_t        kind;
		logic [IDX_W-1:0] idx;
	} bfa_req_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_DONE
	} bfa_state_t;

endpackage

### rtl/bfa_front.sv
module bfa_front #(
	parameter int PAGE_BYTES   = 4096,
	parameter int ADDRESS_BITS = 48
) (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [bfa_pkg::FIELD_W-1:0]    s_axis_tdata,   // address
	input  logic [1:0]                     s_axis_tuser,   // operation
	input  logic [ADDRESS_BITS-1:0]        base,
	input  logic [bfa_pkg::CNT_W-1:0]      num_frames,
	input  logic                           clearing,
	output logic                           push_valid,
	input  logic                           push_ready,
	output bfa_pkg::bfa_req_t              push_req
);

	localparam int AW = ADDRESS_BITS;
	localparam int PS = $clog2(PAGE_BYTES);

	logic [AW-1:0] addr_a;
	logic [AW-1:0] off;
	logic [AW-1:0] fi;
	logic          hit;

	assign addr_a = AW'(s_axis_tdata);
	assign off    = addr_a - base;
	assign fi     = off >> PS;
	assign hit    = (addr_a >= base) && (off[PS-1:0] == '0) && (fi < AW'(num_frames));

	assign s_axis_tready = push_ready && !clearing;
	assign push_valid    = s_axis_tvalid && !clearing;

	always_comb begin
		push_req.idx = fi[bfa_pkg::IDX_W-1:0];
		case (s_axis_tuser)
			bfa_pkg::OP_ALLOC: push_req.kind = bfa_pkg::K_ALLOC;
			bfa_pkg::OP_FREE:  push_req.kind = hit ? bfa_pkg::K_FREE : bfa_pkg::K_NONE;
			bfa_pkg::OP_QUERY: push_req.kind = hit ? bfa_pkg::K_QUERY : bfa_pkg::K_NONE;
			default:           push_req.kind = bfa_pkg::K_NONE;
		endcase
	end

endmodule

### rtl/bfa_queue.sv
module bfa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  bfa_pkg::bfa_req_t push_req,
	output logic              pop_valid,
	input  logic              pop_ready,
	output bfa_pkg::bfa_req_t pop_req
);

	bfa_pkg::bfa_req_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_req    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/bfa_back.sv
module bfa_back #(
	parameter int FRAME_CAPACITY = 4096,
	parameter int PAGE_BYTES     = 4096,
	parameter int ADDRESS_BITS   = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic [ADDRESS_BITS-1:0]        base,
	input  logic [bfa_pkg::CNT_W-1:0]      num_frames,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  bfa_pkg::bfa_req_t              req,
	output logic                           clearing,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [63:0]                    m_axis_tdata
);

	localparam int AW    = ADDRESS_BITS;
	localparam int PS    = $clog2(PAGE_BYTES);
	localparam int WORDS = FRAME_CAPACITY / bfa_pkg::WORD_W;
	localparam int WI    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SW    = bfa_pkg::WORD_SH;
	localparam int FW    = WI + SW;

	logic [bfa_pkg::WORD_W-1:0] mem [WORDS];
	logic [bfa_pkg::WORD_W-1:0] rdata_q;

	bfa_pkg::bfa_state_t state_q;
	bfa_pkg::bfa_state_t state_d;
	bfa_pkg::bfa_req_t   cur_q;
	logic [WI-1:0]               ptr_q;
	logic [bfa_pkg::CNT_W-1:0]   free_q;
	logic [bfa_pkg::FIELD_W-1:0] res_addr_q;
	logic                        res_ok_q;
	logic                        res_used_q;
	logic                        out_valid_q;
	logic [63:0]                 out_data_q;

	logic                        re;
	logic [WI-1:0]               raddr;
	logic                        we;
	logic [WI-1:0]               waddr;
	logic [bfa_pkg::WORD_W-1:0]  wdata;

	logic [bfa_pkg::WORD_W-1:0]  valid_mask;
	logic [bfa_pkg::WORD_W-1:0]  avail;
	logic [bfa_pkg::WORD_W-1:0]  low_bit;
	logic [SW-1:0]               low_b;
	logic                        found;
	logic                        more;
	logic [13:0]                 fc_sum;
	logic [FW-1:0]               alloc_idx;
	logic [AW-1:0]               alloc_addr;
	logic                        cur_bit;
	logic [bfa_pkg::WORD_W-1:0]  cur_mask;
	logic                        out_free;
	logic                        last_clear;

	assign clearing      = (state_q == bfa_pkg::BK_CLEAR);
	assign req_ready     = (state_q == bfa_pkg::BK_IDLE) && !clear;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign last_clear    = (ptr_q == WI'(WORDS - 1));

	always_comb begin
		if (14'(ptr_q) < 14'(num_frames[bfa_pkg::CNT_W-1:SW])) begin
			valid_mask = '1;
		end else if (14'(ptr_q) == 14'(num_frames[bfa_pkg::CNT_W-1:SW])) begin
			valid_mask = (64'd1 << num_frames[SW-1:0]) - 64'd1;
		end else begin
			valid_mask = '0;
		end
	end

	always_comb begin
		low_b = '0;
		for (int i = bfa_pkg::WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				low_b = SW'(i);
			end
		end
	end

	assign avail      = ~rdata_q & valid_mask;
	assign low_bit    = avail & (~avail + 64'd1);
	assign found      = (avail != '0);
	assign fc_sum     = 14'(num_frames) + 14'd63;
	assign more       = (14'(ptr_q) + 14'd1) < 14'(fc_sum[13:SW]);
	assign alloc_idx  = {ptr_q, low_b};
	assign alloc_addr = base + AW'({alloc_idx, {PS{1'b0}}});
	assign cur_bit    = rdata_q[cur_q.idx[SW-1:0]];
	assign cur_mask   = 64'd1 << cur_q.idx[SW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfa_pkg::BK_CLEAR: begin
				if (last_clear) begin
					state_d = bfa_pkg::BK_IDLE;
				end
			end
			bfa_pkg::BK_IDLE: begin
				if (req_valid) begin
					if (req.kind == bfa_pkg::K_NONE ||
					    (req.kind == bfa_pkg::K_ALLOC && free_q == '0)) begin
						state_d = bfa_pkg::BK_DONE;
					end else begin
						state_d = bfa_pkg::BK_READ;
					end
				end
			end
			bfa_pkg::BK_READ: state_d = bfa_pkg::BK_EXEC;
			bfa_pkg::BK_EXEC: begin
				if (!(cur_q.kind == bfa_pkg::K_ALLOC && !found && more)) begin
					state_d = bfa_pkg::BK_DONE;
				end
			end
			bfa_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = bfa_pkg::BK_IDLE;
				end
			end
			default: state_d = bfa_pkg::BK_CLEAR;
		endcase
		if (clear) begin
			state_d = bfa_pkg::BK_CLEAR;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q;
		we    = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		case (state_q)
			bfa_pkg::BK_CLEAR: we = 1'b1;
			bfa_pkg::BK_READ:  re = 1'b1;
			bfa_pkg::BK_EXEC: begin
				case (cur_q.kind)
					bfa_pkg::K_ALLOC: begin
						re    = 1'b1;
						raddr = ptr_q + WI'(1);
						we    = found;
						wdata = rdata_q | low_bit;
					end
					bfa_pkg::K_FREE: begin
						we    = cur_bit;
						wdata = rdata_q & ~cur_mask;
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bfa_pkg::BK_IDLE && req_valid && !clear) begin
			cur_q      <= req;
			res_addr_q <= '0;
			res_ok_q   <= 1'b0;
			res_used_q <= 1'b0;
		end else if (state_q == bfa_pkg::BK_EXEC) begin
			case (cur_q.kind)
				bfa_pkg::K_ALLOC: begin
					if (found) begin
						res_addr_q <= bfa_pkg::FIELD_W'(alloc_addr);
						res_ok_q   <= 1'b1;
					end
				end
				bfa_pkg::K_FREE:  res_ok_q   <= cur_bit;
				bfa_pkg::K_QUERY: res_used_q <= cur_bit;
				default:          res_ok_q   <= 1'b0;
			endcase
		end
		if (state_q == bfa_pkg::BK_DONE && out_free) begin
			out_data_q <= {1'b0, free_q, res_used_q, res_ok_q, res_addr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfa_pkg::BK_CLEAR;
			ptr_q       <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				ptr_q <= '0;
			end else begin
				case (state_q)
					bfa_pkg::BK_CLEAR: begin
						ptr_q  <= ptr_q + WI'(1);
						free_q <= num_frames;
					end
					bfa_pkg::BK_IDLE: begin
						if (req_valid) begin
							ptr_q <= (req.kind == bfa_pkg::K_ALLOC) ? '0 :
							         WI'(req.idx >> SW);
						end
					end
					bfa_pkg::BK_EXEC: begin
						case (cur_q.kind)
							bfa_pkg::K_ALLOC: begin
								if (found) begin
									free_q <= free_q - bfa_pkg::CNT_W'(1);
								end else if (more) begin
									ptr_q <= ptr_q + WI'(1);
								end
							end
							bfa_pkg::K_FREE: begin
								if (cur_bit) begin
									free_q <= free_q + bfa_pkg::CNT_W'(1);
								end
							end
							default: begin
								free_q <= free_q;
							end
						endcase
					end
					default: begin
						ptr_q <= ptr_q;
					end
				endcase
			end
			if (state_q == bfa_pkg::BK_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/bitmap_frame_allocator_core.sv
// A valid free or query passes from the queue through back states READ, EXEC and DONE to
// the output register; a rejected free or query, an unused code or an allocate with no free
// frame goes from IDLE to DONE, and an allocate repeats EXEC once per bitmap word scanned.
// The back sequencer holds one item at a time until its result is registered; two requests
// can wait in the queue while a result waits in the output register. Reset and each write to
// a mapped register clear every bitmap word with no input transfer taken.
module bitmap_frame_allocator_core #(
	parameter int FRAME_CAPACITY = 4096,
	parameter int PAGE_BYTES     = 4096,
	parameter int ADDRESS_BITS   = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bfa_pkg::FIELD_W-1:0]       s_axis_tdata,  // address[47:0]
	input  logic [1:0]                        s_axis_tuser,  // operation[1:0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// result_address[47:0], success[48], is_allocated[49], free_count[62:50], zero[63]
	output logic [63:0]                       m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bfa_pkg::FIELD_W-1:0]       cfg_data
);

	localparam int AW = ADDRESS_BITS;
	localparam int PS = $clog2(PAGE_BYTES);

	logic [AW-1:0]             base_q;
	logic [bfa_pkg::CNT_W-1:0] fcount_q;
	logic [AW:0]               base_sum;
	logic [AW-1:0]             base_round;
	logic [bfa_pkg::CNT_W-1:0] count_sat;
	logic                      cfg_xfer;
	logic                      clear;
	logic                      clearing;
	logic                      push_valid;
	logic                      push_ready;
	bfa_pkg::bfa_req_t         push_req;
	logic                      pop_valid;
	logic                      pop_ready;
	bfa_pkg::bfa_req_t         pop_req;

	assign cfg_ready  = 1'b1;
	assign cfg_xfer   = cfg_valid && cfg_ready;
	assign clear      = cfg_xfer && (cfg_index == bfa_pkg::REG_BASE_ADDRESS ||
	                                 cfg_index == bfa_pkg::REG_FRAME_COUNT);
	assign base_sum   = (AW + 1)'(AW'(cfg_data)) + (AW + 1)'(PAGE_BYTES - 1);
	assign base_round = {base_sum[AW-1:PS], {PS{1'b0}}};
	assign count_sat  = (32'(cfg_data[bfa_pkg::CNT_W-1:0]) > 32'(FRAME_CAPACITY)) ?
	                    bfa_pkg::CNT_W'(FRAME_CAPACITY) : cfg_data[bfa_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			fcount_q <= '0;
		end else if (cfg_xfer) begin
			if (cfg_index == bfa_pkg::REG_BASE_ADDRESS) begin
				base_q <= base_round;
			end else if (cfg_index == bfa_pkg::REG_FRAME_COUNT) begin
				fcount_q <= count_sat;
			end
		end
	end

	bfa_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.base          (base_q),
		.num_frames    (fcount_q),
		.clearing      (clearing),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_req      (push_req)
	);

	bfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	bfa_back #(
		.FRAME_CAPACITY (FRAME_CAPACITY),
		.PAGE_BYTES     (PAGE_BYTES),
		.ADDRESS_BITS   (ADDRESS_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (clear),
		.base          (base_q),
		.num_frames    (fcount_q),
		.req_valid     (pop_valid),
		.req_ready     (pop_ready),
		.req           (pop_req),
		.clearing      (clearing),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
